// ===== sv/kvl_pkg.sv =====
package kvl_pkg;

  localparam int SLOT_REACH = 32;
  localparam int SLOT_W     = 5;
  localparam int KC_W       = 6;
  localparam int VAL_W      = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DSR_W      = 32;
  localparam int DVD_W      = DSR_W + FRAC_BITS;
  localparam int CHUNK_W    = 16;
  localparam int DMAG_W     = VAL_W + 1;
  localparam int PP_W       = CHUNK_W + DMAG_W;
  localparam int ACC_W      = DVD_W + DMAG_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE_RD,
    S_ONE_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SEG0_RD,
    S_SEG1_RD,
    S_SEG1_WAIT,
    S_DIV,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_FIN,
    S_DONE
  } kvl_state_t;

endpackage

// ===== sv/kvl_div.sv =====
module kvl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kvl_pkg::DVD_W-1:0]  dividend,
  input  logic [kvl_pkg::DSR_W-1:0]  divisor,
  output logic                       done,
  output logic [kvl_pkg::DVD_W-1:0]  quotient
);
  import kvl_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // restoring step: one quotient bit a cycle, quotient shifts in behind the dividend
  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], ge};
      rem <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign quotient = dvd;

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < dsr) else $error("divider remainder not below divisor");
  a_start_load: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == CNT_W'(DVD_W)) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");

endmodule

// ===== sv/keyframe_vector_lerp.sv =====
// Keyframe interpolator for a three-component Q16.16 vector. A request with tuser low
// writes one keyframe (time and x/y/z) into the slot it names, if that slot is below
// the table depth; a request with tuser high samples the table at query_time and
// returns one result. Entries must be written before a query reads them: the table
// is not cleared.
// key_count selects how many keys are in use. A query walks the keys through the
// single table read port, one read and one compare per key, reads the two keys of the
// segment, divides one quotient bit a cycle for a 48-bit quotient and runs each
// component through one shared 16x33 multiplier in three partial products. A single
// key skips the search and the division, and equal segment times skip the division
// and the multiplier. The result is registered once the output register is free, and
// the block then returns to idle for the next request.
// The block takes no request while a query is in progress; a finished result is
// held in the output register so the next request can be taken meanwhile.
module keyframe_vector_lerp #(
  parameter int MAX_KEYS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [kvl_pkg::KC_W-1:0]       cfg_wr_data,  // key_count
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // key_slot[4:0], key_time[36:5], key_x[68:37], key_y[100:69], key_z[132:101],
  // query_time[164:133], zero pad
  input  logic [167:0]                   s_tdata,
  input  logic                           s_tuser,      // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], segment[100:96], zero pad
  output logic [103:0]                   m_tdata,
  output logic                           m_tuser       // degenerate
);
  import kvl_pkg::*;

  localparam int DEPTH = (MAX_KEYS < SLOT_REACH) ? MAX_KEYS : SLOT_REACH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [KC_W-1:0] DEPTH_N = KC_W'(DEPTH);

  // request fields
  logic [SLOT_W-1:0]  in_slot;
  logic [VAL_W-1:0]   in_time;
  logic [3*VAL_W-1:0] in_val;
  logic [VAL_W-1:0]   in_query;

  assign in_slot  = s_tdata[4:0];
  assign in_time  = s_tdata[36:5];
  assign in_val   = s_tdata[132:37];
  assign in_query = s_tdata[164:133];

  kvl_state_t state, state_next;

  logic [KC_W-1:0]    key_count;
  logic [KC_W-1:0]    n_eff;
  logic [KC_W-1:0]    n_r;
  logic [VAL_W-1:0]   q;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  seg;
  logic               degen;

  logic [VAL_W-1:0]   time_mem [DEPTH];
  logic [3*VAL_W-1:0] val_mem  [DEPTH];
  logic [VAL_W-1:0]   rd_time;
  logic [3*VAL_W-1:0] rd_val;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  logic [VAL_W-1:0]   t0;
  logic [VAL_W-1:0]   st [3];
  logic [VAL_W-1:0]   en [3];
  logic [VAL_W-1:0]   res [3];

  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   div_quot;
  logic [DSR_W-1:0]   num_mag;
  logic [DSR_W-1:0]   den_mag;
  logic               num_neg_c;
  logic               den_neg_c;

  logic [DVD_W-1:0]   fmag;
  logic               fneg;
  logic [DMAG_W-1:0]  dmag;
  logic               dneg;
  logic [1:0]         comp;
  logic [1:0]         ch;
  logic [PP_W-1:0]    pp;
  logic [ACC_W-1:0]   acc;

  logic               load_acc;
  logic               query_acc;
  logic               srch_hit;
  logic               srch_last;
  logic               out_free;

  logic signed [DMAG_W-1:0] d_c;
  logic                     neg_c;
  logic                     ovf_c;
  logic signed [48:0]       sv_c;
  logic signed [48:0]       step_c;
  logic signed [48:0]       sum_c;
  logic [VAL_W-1:0]         fin_c;

  function automatic logic [31:0] sat49(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  assign load_acc  = s_tvalid && s_tready && !s_tuser;
  assign query_acc = s_tvalid && s_tready && s_tuser;
  assign srch_hit  = q < rd_time;
  assign srch_last = ({1'b0, idx} + KC_W'(2)) == n_r;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (key_count == '0) begin
      n_eff = KC_W'(1);
    end else if (key_count > DEPTH_N) begin
      n_eff = DEPTH_N;
    end else begin
      n_eff = key_count;
    end
  end

  // segment operands straight from the read port
  assign num_neg_c = q < t0;
  assign den_neg_c = rd_time < t0;
  assign num_mag   = num_neg_c ? (t0 - q) : (q - t0);
  assign den_mag   = den_neg_c ? (t0 - rd_time) : (rd_time - t0);

  kvl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (div_quot)
  );

  // component finish: step = trunc(|f*d| / 2^16) applied in the product sign
  assign d_c    = DMAG_W'($signed(en[comp])) - DMAG_W'($signed(st[comp]));
  assign neg_c  = fneg ^ dneg;
  assign ovf_c  = acc > (ACC_W'(1) << 62);
  assign sv_c   = 49'($signed(st[comp]));
  assign step_c = $signed({2'b00, acc[62:FRAC_BITS]});
  assign sum_c  = neg_c ? (sv_c - step_c) : (sv_c + step_c);
  assign fin_c  = ovf_c ? (neg_c ? 32'h8000_0000 : 32'h7fff_ffff) : sat49(sum_c);

  // keyframe table
  always_ff @(posedge clk) begin
    if (load_acc && (KC_W'(in_slot) < DEPTH_N)) begin
      time_mem[in_slot[AW-1:0]] <= in_time;
      val_mem[in_slot[AW-1:0]]  <= in_val;
    end
    if (rd_en) begin
      rd_time <= time_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (query_acc) begin
          state_next = (n_eff == KC_W'(1)) ? S_ONE_RD : S_SRCH_RD;
        end
      end
      S_ONE_RD:    state_next = S_ONE_WAIT;
      S_ONE_WAIT:  state_next = S_DONE;
      S_SRCH_RD:   state_next = S_SRCH_CMP;
      S_SRCH_CMP:  state_next = (srch_hit || srch_last) ? S_SEG0_RD : S_SRCH_RD;
      S_SEG0_RD:   state_next = S_SEG1_RD;
      S_SEG1_RD:   state_next = S_SEG1_WAIT;
      S_SEG1_WAIT: state_next = (rd_time == t0) ? S_DONE : S_DIV;
      S_DIV:       state_next = div_done ? S_DIFF : S_DIV;
      S_DIFF:      state_next = S_MUL;
      S_MUL:       state_next = S_ACC;
      S_ACC:       state_next = (ch == 2'd2) ? S_FIN : S_MUL;
      S_FIN:       state_next = (comp == 2'd2) ? S_DONE : S_DIFF;
      S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:    s_tready = 1'b1;
      S_ONE_RD:  rd_en = 1'b1;
      S_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx + SLOT_W'(1));
      end
      S_SEG0_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(seg);
      end
      S_SEG1_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(seg + SLOT_W'(1));
      end
      S_SEG1_WAIT: div_start = rd_time != t0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= KC_W'(1);
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        key_count <= cfg_wr_data;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        q     <= in_query;
        n_r   <= n_eff;
        idx   <= '0;
        seg   <= '0;
        degen <= 1'b0;
      end
      S_ONE_WAIT: begin
        for (int k = 0; k < 3; k++) begin
          res[k] <= rd_val[k*VAL_W +: VAL_W];
        end
      end
      S_SRCH_CMP: begin
        if (srch_hit) begin
          seg <= idx;
        end else if (srch_last) begin
          seg <= '0;
        end else begin
          idx <= idx + SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
    // seg+1 entry lands in the cycle after the start entry
    if (state == S_SEG1_RD) begin
      t0 <= rd_time;
      for (int k = 0; k < 3; k++) begin
        st[k] <= rd_val[k*VAL_W +: VAL_W];
      end
    end
    if (state == S_SEG1_WAIT) begin
      for (int k = 0; k < 3; k++) begin
        en[k]  <= rd_val[k*VAL_W +: VAL_W];
        res[k] <= st[k];
      end
      fneg  <= num_neg_c ^ den_neg_c;
      degen <= rd_time == t0;
      comp  <= '0;
    end
    if (state == S_DIV && div_done) begin
      fmag <= div_quot;
    end
    if (state == S_DIFF) begin
      dmag <= d_c[DMAG_W-1] ? DMAG_W'(-d_c) : DMAG_W'(d_c);
      dneg <= d_c[DMAG_W-1];
      ch   <= '0;
      acc  <= '0;
    end
    if (state == S_MUL) begin
      pp <= {{DMAG_W{1'b0}}, fmag[ch*CHUNK_W +: CHUNK_W]} * {{CHUNK_W{1'b0}}, dmag};
    end
    if (state == S_ACC) begin
      acc <= acc + (ACC_W'(pp) << {ch, 4'b0000});
      ch  <= ch + 2'd1;
    end
    if (state == S_FIN) begin
      res[comp] <= fin_c;
      comp      <= comp + 2'd1;
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {3'b000, seg, res[2], res[1], res[0]};
      m_tuser <= degen;
    end
  end

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> state == S_IDLE) else $error("load request left idle");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_tvalid) else $error("result not presented");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH_CMP |-> ({1'b0, idx} + KC_W'(2)) <= n_r)
    else $error("search ran past the keys in use");

endmodule
